/* hw/rtl/idsa_pkg.sv */
// Shared types and constants for the inverse-distance scatter accumulator.
// No dependencies.
`default_nettype none
package idsa_pkg;
  localparam int GRID_POINTS = 4096;
  localparam int IDX_W = 12;
  localparam int COORD_FRAC_BITS = 8;

  localparam logic [1:0] ACT_LOAD    = 2'd0;
  localparam logic [1:0] ACT_ACC     = 2'd1;
  localparam logic [1:0] ACT_READ    = 2'd2;
  localparam logic [1:0] ACT_UNKNOWN = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DST = 2'd1;
  localparam logic [1:0] ST_ZERO_WT  = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_CLEAR    = 2'd0;
  localparam logic [1:0] KIND_ZERO_DST = 2'd1;
  localparam logic [1:0] KIND_ZERO_WT  = 2'd2;
  localparam logic [1:0] KIND_RESULT   = 2'd3;

  // divider / lane select
  localparam logic [2:0] SEL_WEIGHT = 3'd0;
  localparam logic [2:0] SEL_SUM_A  = 3'd1;
  localparam logic [2:0] SEL_SUM_C  = 3'd3;
  localparam logic [2:0] SEL_SUM_D  = 3'd4;

  localparam logic [63:0] WEIGHT_NUM = 64'd1 << (32 + COORD_FRAC_BITS);

  // datapath commands
  typedef struct packed {
    logic       latch_in;   // capture input item, start memory read
    logic       load_in;    // capture read data
    logic       write_load; // write load item
    logic       write_acc;  // write accumulated sums
    logic       sqrt_step;
    logic       div_init;   // init divider, operand chosen by div_sel
    logic [2:0] div_sel;    // 0 weight, 1..4 sums a..d
    logic       div_step;
    logic       mac_step;   // one scaled-term product step, lane by div_sel
    logic       acc_add;    // saturating add of lane div_sel, weight on sel 4
    logic       div_store;  // store quotient of lane div_sel
    logic       out_fire;
    logic [1:0] out_kind;
  } idsa_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       d2_zero;
    logic       wt_zero;
  } idsa_sts_t;
endpackage
`default_nettype wire

/* hw/rtl/inverse_distance_scatter_accumulate_unit.sv */
// Top level: controller plus datapath.
// Depends on idsa_pkg, idsa_ctrl, idsa_datapath.
//
//  channel | handshake         | ports
//  input   | start & !busy     | in_*
//  result  | out_valid strobe  | out_*
//
// An item holds the unit from its accepting edge to the next possible one, its strobe
// in the last cycle. Load and ignored items are shortest; zero-distance and zero-weight
// cases stop after the memory read; an accumulate runs the square root, the weight
// division and the multiply/add steps; a read runs four divisions through the one
// shared divider. The result side cannot stall. Synchronous active-low reset
// clears the controller only; memories need no clearing pass.
`default_nettype none
module inverse_distance_scatter_accumulate_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_action,
  input  wire logic [11:0]        in_grid_index,
  input  wire logic [15:0]        in_coord_x,
  input  wire logic [15:0]        in_coord_y,
  input  wire logic [15:0]        in_coord_z,
  input  wire logic signed [31:0] in_sample_a,
  input  wire logic signed [31:0] in_sample_b,
  input  wire logic signed [31:0] in_sample_c,
  input  wire logic signed [31:0] in_sample_d,
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output logic signed [31:0]      out_average_a,
  output logic signed [31:0]      out_average_b,
  output logic signed [31:0]      out_average_c,
  output logic signed [31:0]      out_average_d,
  output logic [63:0]             out_total_weight
);
  import idsa_pkg::*;
  idsa_cmd_t cmd;
  idsa_sts_t sts;

  idsa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .grid_index(in_grid_index),
    .action(in_action), .sts(sts), .cmd(cmd), .busy(busy), .out_valid(out_valid));

  idsa_datapath u_dp (
    .clk(clk), .cmd(cmd), .sts(sts),
    .in_action(in_action), .in_grid_index(in_grid_index),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y), .in_coord_z(in_coord_z),
    .in_sample_a(in_sample_a), .in_sample_b(in_sample_b),
    .in_sample_c(in_sample_c), .in_sample_d(in_sample_d),
    .out_status(out_status), .out_average_a(out_average_a),
    .out_average_b(out_average_b), .out_average_c(out_average_c),
    .out_average_d(out_average_d), .out_total_weight(out_total_weight));
endmodule
`default_nettype wire

/* hw/rtl/idsa_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module idsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

/* hw/rtl/idsa_datapath.sv */
// Datapath: point memories, square-root and restoring divider units, MAC.
// Depends on idsa_pkg and idsa_ram.
`default_nettype none
module idsa_datapath (
  input  wire logic               clk,
  input  wire idsa_pkg::idsa_cmd_t cmd,
  output idsa_pkg::idsa_sts_t     sts,
  input  wire logic [1:0]         in_action,
  input  wire logic [11:0]        in_grid_index,
  input  wire logic [15:0]        in_coord_x,
  input  wire logic [15:0]        in_coord_y,
  input  wire logic [15:0]        in_coord_z,
  input  wire logic signed [31:0] in_sample_a,
  input  wire logic signed [31:0] in_sample_b,
  input  wire logic signed [31:0] in_sample_c,
  input  wire logic signed [31:0] in_sample_d,
  output logic [1:0]              out_status,
  output logic signed [31:0]      out_average_a,
  output logic signed [31:0]      out_average_b,
  output logic signed [31:0]      out_average_c,
  output logic signed [31:0]      out_average_d,
  output logic [63:0]             out_total_weight
);
  import idsa_pkg::*;

  logic [1:0]  act_r;
  logic [11:0] idx_r;
  logic [15:0] cx_r, cy_r, cz_r;
  logic [31:0] smp_r [4];
  logic [47:0] pos_q;
  logic [63:0] sum_q [4];
  logic [63:0] wt_q;
  logic [63:0] sum_r [4];
  logic [63:0] wt_r;
  logic [34:0] d2_r;

  // memories
  logic        we;
  logic [47:0] pos_wd;
  logic [63:0] sum_wd [4];
  logic [63:0] wt_wd;
  assign we = cmd.write_load | cmd.write_acc;
  assign pos_wd = {in_coord_z, in_coord_y, in_coord_x};

  idsa_ram #(.WIDTH(48), .DEPTH(GRID_POINTS)) u_pos (
    .clk(clk), .we(cmd.write_load), .addr(cmd.latch_in ? in_grid_index : idx_r),
    .wdata(pos_wd), .rdata(pos_q));
  for (genvar g = 0; g < 4; g++) begin : g_sum
    assign sum_wd[g] = cmd.write_load ? 64'd0 : sum_r[g];
    idsa_ram #(.WIDTH(64), .DEPTH(GRID_POINTS)) u_sum (
      .clk(clk), .we(we), .addr(cmd.latch_in ? in_grid_index : idx_r),
      .wdata(sum_wd[g]), .rdata(sum_q[g]));
  end
  assign wt_wd = cmd.write_load ? 64'd0 : wt_r;
  idsa_ram #(.WIDTH(64), .DEPTH(GRID_POINTS)) u_wt (
    .clk(clk), .we(we), .addr(cmd.latch_in ? in_grid_index : idx_r),
    .wdata(wt_wd), .rdata(wt_q));

  function automatic logic [31:0] dsq(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] d;
    d = (a > b) ? a - b : b - a;
    return {16'd0, d} * {16'd0, d};
  endfunction

  // sqrt: two radicand bits per step on (d2 << 16), 52 bits -> 26-bit root
  logic [49:0] sq_rem_r;
  logic [25:0] sq_root_r;
  logic [4:0]  sq_cnt_r;
  logic [51:0] sq_v_r;
  logic [51:0] sq_trial;
  logic [51:0] sq_rem_sh;
  assign sq_rem_sh = {sq_rem_r, sq_v_r[51:50]};
  assign sq_trial  = sq_rem_sh - {24'd0, sq_root_r, 2'b01};

  // divider: 64-bit restoring, one quotient bit per step, 80 bits covers Q16 extension
  logic [63:0] dv_rem_r;
  logic [79:0] dv_num_r;
  logic [63:0] dv_den_r;
  logic [79:0] dv_q_r;
  logic [64:0] dv_sh;
  logic [65:0] dv_sub;
  logic        dv_neg_r;
  assign dv_sh  = {dv_rem_r, dv_num_r[79]};
  assign dv_sub = {1'b0, dv_sh} - {2'b0, dv_den_r};

  logic [63:0] num_sel;
  logic        num_neg;
  always_comb begin
    num_neg = 1'b0;
    num_sel = WEIGHT_NUM;
    if (cmd.div_sel != SEL_WEIGHT) begin
      num_neg = sum_r[cmd.div_sel[1:0] - 2'd1][63];
      num_sel = num_neg ? 64'd0 - sum_r[cmd.div_sel[1:0] - 2'd1]
                        : sum_r[cmd.div_sel[1:0] - 2'd1];
    end
  end

  // scaled term: magnitude * weight halves, registered partials
  logic [1:0]  ln;
  logic [31:0] mag;
  logic        sneg;
  logic [63:0] p_hi_r, p_lo_r;
  logic [63:0] term;
  logic [63:0] acc_s;
  logic        ovf;
  logic [63:0] w_r;
  assign ln   = cmd.div_sel[1:0];
  assign sneg = smp_r[ln][31];
  assign mag  = sneg ? 32'd0 - smp_r[ln] : smp_r[ln];
  logic [63:0] tmag;
  assign tmag = (p_hi_r << 16) + (p_lo_r >> 16);
  assign term = smp_r[ln][31] ? 64'd0 - tmag : tmag;
  assign acc_s = sum_r[ln] + term;
  assign ovf = (sum_r[ln][63] == term[63]) && (acc_s[63] != sum_r[ln][63]);

  logic [31:0] avg_r [4];
  logic [63:0] wsum;
  assign wsum = wt_r + w_r;

  logic [79:0] qv;
  logic [31:0] qsat;
  always_comb begin
    qv = dv_q_r;
    if (dv_neg_r) qsat = (qv > 80'h80000000) ? 32'h80000000 : 32'(80'd0 - qv);
    else          qsat = (qv > 80'h7FFFFFFF) ? 32'h7FFFFFFF : qv[31:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      act_r <= in_action; idx_r <= in_grid_index;
      cx_r <= in_coord_x; cy_r <= in_coord_y; cz_r <= in_coord_z;
      smp_r[0] <= in_sample_a; smp_r[1] <= in_sample_b;
      smp_r[2] <= in_sample_c; smp_r[3] <= in_sample_d;
    end
    if (cmd.load_in) begin
      for (int i = 0; i < 4; i++) sum_r[i] <= sum_q[i];
      wt_r <= wt_q;
      d2_r <= 35'(dsq(cx_r, pos_q[15:0])) + 35'(dsq(cy_r, pos_q[31:16]))
            + 35'(dsq(cz_r, pos_q[47:32]));
      sq_rem_r <= '0; sq_root_r <= '0; sq_cnt_r <= '0;
      sq_v_r <= '0;
    end
    if (cmd.sqrt_step) begin
      if (sq_cnt_r == 5'd0) sq_v_r <= {1'b0, d2_r, 16'd0};
      // first step only loads operand
      if (sq_cnt_r != 5'd0) begin
        sq_v_r <= {sq_v_r[49:0], 2'b00};
        if (!sq_trial[51]) begin
          sq_rem_r <= sq_trial[49:0]; sq_root_r <= {sq_root_r[24:0], 1'b1};
        end else begin
          sq_rem_r <= sq_rem_sh[49:0]; sq_root_r <= {sq_root_r[24:0], 1'b0};
        end
      end
      sq_cnt_r <= sq_cnt_r + 5'd1;
    end
    if (cmd.div_init) begin
      dv_rem_r <= '0;
      dv_q_r   <= '0;
      dv_neg_r <= num_neg;
      if (cmd.div_sel == SEL_WEIGHT) begin
        dv_num_r <= {16'd0, num_sel};
        dv_den_r <= {38'd0, sq_root_r};
      end else begin
        dv_num_r <= {num_sel, 16'd0};
        dv_den_r <= wt_r;
      end
    end
    if (cmd.div_step) begin
      dv_num_r <= {dv_num_r[78:0], 1'b0};
      if (!dv_sub[65]) begin
        dv_rem_r <= dv_sub[63:0]; dv_q_r <= {dv_q_r[78:0], 1'b1};
      end else begin
        dv_rem_r <= dv_sh[63:0]; dv_q_r <= {dv_q_r[78:0], 1'b0};
      end
    end
    if (cmd.div_store) begin
      if (cmd.div_sel == SEL_WEIGHT) w_r <= dv_q_r[63:0];
      else avg_r[cmd.div_sel[1:0] - 2'd1] <= qsat;
    end
    if (cmd.mac_step) begin
      p_hi_r <= 64'(mag) * 64'(w_r[63:32]);
      p_lo_r <= 64'(mag) * 64'(w_r[31:0]);
    end
    if (cmd.acc_add) begin
      if (cmd.div_sel == SEL_SUM_D) begin
        wt_r <= (wsum < w_r) ? '1 : wsum;
      end else begin
        sum_r[ln] <= ovf ? (sum_r[ln][63] ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF)
                         : acc_s;
      end
    end
    if (cmd.out_fire) begin
      out_status <= ST_OK;
      out_average_a <= '0; out_average_b <= '0;
      out_average_c <= '0; out_average_d <= '0;
      out_total_weight <= '0;
      case (cmd.out_kind)
        KIND_ZERO_DST: begin out_status <= ST_ZERO_DST; out_total_weight <= wt_r; end
        KIND_ZERO_WT: out_status <= ST_ZERO_WT;
        KIND_RESULT: begin
          out_total_weight <= wt_r;
          if (act_r == ACT_READ) begin
            out_average_a <= avg_r[0]; out_average_b <= avg_r[1];
            out_average_c <= avg_r[2]; out_average_d <= avg_r[3];
          end
        end
        default: ;
      endcase
    end
  end

  assign sts.action  = act_r;
  assign sts.d2_zero = (d2_r == '0);
  assign sts.wt_zero = (wt_r == '0);
endmodule
`default_nettype wire

/* hw/rtl/idsa_ctrl.sv */
// Controller sequencing load, accumulate and read items.
// Depends on idsa_pkg.
`default_nettype none
module idsa_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [11:0]         grid_index,
  input  wire logic [1:0]          action,
  input  wire idsa_pkg::idsa_sts_t sts,
  output idsa_pkg::idsa_cmd_t      cmd,
  output logic                     busy,
  output logic                     out_valid
);
  import idsa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_LD, S_DISPATCH, S_SQRT, S_DINIT, S_DSTEP, S_DSTORE,
    S_MUL, S_ADD, S_WRITE, S_OUT
  } state_t;

  state_t      state_r, state_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [2:0]  sel_r, sel_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic        valid_r, valid_nxt;
  logic        accept;

  assign accept = start && !busy;
  assign busy = (state_r != S_IDLE);
  assign out_valid = valid_r;

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; sel_nxt = sel_r; kind_nxt = kind_r;
    valid_nxt = 1'b0;
    cmd = '0;
    cmd.div_sel = sel_r;
    cmd.out_kind = kind_r;
    case (state_r)
      S_IDLE: if (accept) begin
        cmd.latch_in = 1'b1;
        if (action == ACT_LOAD) cmd.write_load = 1'b1;
        kind_nxt = KIND_CLEAR;
        if (32'(grid_index) >= GRID_POINTS || action == ACT_UNKNOWN || action == ACT_LOAD)
          state_nxt = S_OUT;
        else state_nxt = S_RD;
      end
      S_RD: state_nxt = S_LD;
      S_LD: begin cmd.load_in = 1'b1; state_nxt = S_DISPATCH; end
      S_DISPATCH: begin
        if (sts.action == ACT_ACC) begin
          if (sts.d2_zero) begin kind_nxt = KIND_ZERO_DST; state_nxt = S_OUT; end
          else begin cnt_nxt = '0; state_nxt = S_SQRT; end
          sel_nxt = SEL_WEIGHT;
        end else begin
          if (sts.wt_zero) begin kind_nxt = KIND_ZERO_WT; state_nxt = S_OUT; end
          else begin sel_nxt = SEL_SUM_A; state_nxt = S_DINIT; end
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd26) state_nxt = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt = '0; state_nxt = S_DSTEP;
      end
      S_DSTEP: begin
        cmd.div_step = 1'b1;
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd79) state_nxt = S_DSTORE;
      end
      S_DSTORE: begin
        cmd.div_store = 1'b1;
        if (sel_r == SEL_WEIGHT) state_nxt = S_MUL;
        else if (sel_r == SEL_SUM_D) begin kind_nxt = KIND_RESULT; state_nxt = S_OUT; end
        else begin sel_nxt = sel_r + 3'd1; state_nxt = S_DINIT; end
      end
      S_MUL: begin
        cmd.mac_step = 1'b1; state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.acc_add = 1'b1;
        if (sel_r == SEL_SUM_D) state_nxt = S_WRITE;
        else begin
          sel_nxt = sel_r + 3'd1;
          state_nxt = (sel_r == SEL_SUM_C) ? S_ADD : S_MUL;
        end
      end
      S_WRITE: begin
        cmd.write_acc = 1'b1; kind_nxt = KIND_RESULT; state_nxt = S_OUT;
      end
      S_OUT: begin
        cmd.out_fire = 1'b1; valid_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; valid_r <= 1'b0; cnt_r <= '0; sel_r <= '0; kind_r <= '0;
    end else begin
      state_r <= state_nxt; valid_r <= valid_nxt; cnt_r <= cnt_nxt;
      sel_r <= sel_nxt; kind_r <= kind_nxt;
    end
  end

`ifndef SYNTHESIS
  a_valid_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT |=> valid_r) else $error("no strobe after result");
  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |=> !valid_r) else $error("strobe longer than one cycle");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy) else $error("not busy after accept");
`endif
endmodule
`default_nettype wire

/* test/idsa_checker.sv */
// Checker for the inverse-distance scatter accumulator: watches the input and result
// channels, predicts each result from its own copy of the point table and compares.
// Depends on idsa_pkg.
`timescale 1ns / 1ps
module idsa_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [1:0]  in_action,
  input  wire logic [11:0] in_grid_index,
  input  wire logic [15:0] in_coord_x,
  input  wire logic [15:0] in_coord_y,
  input  wire logic [15:0] in_coord_z,
  input  wire logic [31:0] in_sample_a,
  input  wire logic [31:0] in_sample_b,
  input  wire logic [31:0] in_sample_c,
  input  wire logic [31:0] in_sample_d,
  input  wire logic        out_valid,
  input  wire logic [1:0]  out_status,
  input  wire logic [31:0] out_average_a,
  input  wire logic [31:0] out_average_b,
  input  wire logic [31:0] out_average_c,
  input  wire logic [31:0] out_average_d,
  input  wire logic [63:0] out_total_weight,
  output int               error_count,
  output int               pending_count
);
  import idsa_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] avg_a;
    logic [31:0] avg_b;
    logic [31:0] avg_c;
    logic [31:0] avg_d;
    logic [63:0] weight;
  } idw_result_t;

  logic [15:0] pos_x [GRID_POINTS];
  logic [15:0] pos_y [GRID_POINTS];
  logic [15:0] pos_z [GRID_POINTS];
  logic [63:0] wsum [GRID_POINTS][4];
  logic [63:0] wtot [GRID_POINTS];
  idw_result_t expected_results[$];

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, bit_m;
    res = 0;
    bit_m = 64'd1 << 62;
    while (bit_m > v) bit_m >>= 2;
    while (bit_m != 0) begin
      if (v >= res + bit_m) begin
        v = v - (res + bit_m);
        res = (res >> 1) + bit_m;
      end else begin
        res >>= 1;
      end
      bit_m >>= 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63])
      return a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    return s;
  endfunction

  function automatic logic [63:0] weighted_value(logic [31:0] v, logic [63:0] w);
    logic [63:0] mag, m;
    mag = v[31] ? {32'd0, -v} : {32'd0, v};
    m = ((mag * {32'd0, w[63:32]}) << 16) + ((mag * {32'd0, w[31:0]}) >> 16);
    return v[31] ? -m : m;
  endfunction

  function automatic logic [31:0] normalized(logic [63:0] s, logic [63:0] wt);
    logic [63:0] mag, q, r;
    logic carry;
    mag = s[63] ? -s : s;
    q = mag / wt;
    r = mag % wt;
    if (q >= 64'h1_0000_0000) q = '1;
    else begin
      for (int i = 0; i < 16; i++) begin
        carry = r[63];
        r = r << 1;
        q = q << 1;
        if (carry || r >= wt) begin
          r = r - wt;
          q[0] = 1'b1;
        end
      end
    end
    if (s[63]) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return -q[31:0];
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return q[31:0];
  endfunction

  task automatic predict_transfer();
    idw_result_t r;
    logic [63:0] dx, dy, dz, d2, w, t;
    logic [31:0] vals [4];
    int k;
    k = in_grid_index;
    r = '0;
    vals = '{in_sample_a, in_sample_b, in_sample_c, in_sample_d};
    case (in_action)
      ACT_LOAD: begin
        pos_x[k] = in_coord_x;
        pos_y[k] = in_coord_y;
        pos_z[k] = in_coord_z;
        for (int j = 0; j < 4; j++) wsum[k][j] = 0;
        wtot[k] = 0;
      end
      ACT_ACC: begin
        dx = in_coord_x > pos_x[k] ? in_coord_x - pos_x[k] : pos_x[k] - in_coord_x;
        dy = in_coord_y > pos_y[k] ? in_coord_y - pos_y[k] : pos_y[k] - in_coord_y;
        dz = in_coord_z > pos_z[k] ? in_coord_z - pos_z[k] : pos_z[k] - in_coord_z;
        d2 = dx * dx + dy * dy + dz * dz;
        if (d2 == 0) begin
          r.status = ST_ZERO_DST;
          r.weight = wtot[k];
        end else begin
          w = WEIGHT_NUM / int_sqrt(d2 << 16);
          for (int j = 0; j < 4; j++)
            wsum[k][j] = sat_add(wsum[k][j], weighted_value(vals[j], w));
          t = wtot[k] + w;
          if (t < w) t = '1;
          wtot[k] = t;
          r.weight = t;
        end
      end
      ACT_READ: begin
        if (wtot[k] == 0) r.status = ST_ZERO_WT;
        else begin
          r.avg_a = normalized(wsum[k][0], wtot[k]);
          r.avg_b = normalized(wsum[k][1], wtot[k]);
          r.avg_c = normalized(wsum[k][2], wtot[k]);
          r.avg_d = normalized(wsum[k][3], wtot[k]);
          r.weight = wtot[k];
        end
      end
      default: ;  // unknown action: all-zero result
    endcase
    expected_results = {expected_results, r};
  endtask

  initial begin
    error_count = 0;
    pending_count = 0;
  end

  always @(posedge clk) begin
    idw_result_t e, got;
    if (rst_n) begin
      if (out_valid) begin
        got = '{out_status, out_average_a, out_average_b, out_average_c,
                out_average_d, out_total_weight};
        if (expected_results.size() == 0) begin
          $display("%t: unexpected result %h", $realtime, got);
          error_count++;
        end else begin
          e = expected_results.pop_front();
          if (got.status !== e.status) begin
            $display("%t: status exp %0d got %0d", $realtime, e.status, got.status);
            error_count++;
          end
          if (got.avg_a !== e.avg_a) begin
            $display("%t: average_a exp %h got %h", $realtime, e.avg_a, got.avg_a);
            error_count++;
          end
          if (got.avg_b !== e.avg_b) begin
            $display("%t: average_b exp %h got %h", $realtime, e.avg_b, got.avg_b);
            error_count++;
          end
          if (got.avg_c !== e.avg_c) begin
            $display("%t: average_c exp %h got %h", $realtime, e.avg_c, got.avg_c);
            error_count++;
          end
          if (got.avg_d !== e.avg_d) begin
            $display("%t: average_d exp %h got %h", $realtime, e.avg_d, got.avg_d);
            error_count++;
          end
          if (got.weight !== e.weight) begin
            $display("%t: total_weight exp %h got %h", $realtime, e.weight, got.weight);
            error_count++;
          end
        end
      end
      // an item transferred at this edge: its result cannot appear before the next
      if (start && !busy) predict_transfer();
    end
    pending_count = expected_results.size();
  end
endmodule

/* test/tb_top.sv */
// Testbench top: clock, reset and stimulus for the inverse-distance scatter
// accumulator, checker beside the block. Depends on idsa_pkg, idsa_checker, the unit.
`timescale 1ns / 1ps
module tb_top;
  import idsa_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_action = '0;
  logic [11:0] in_grid_index = '0;
  logic [15:0] in_coord_x = '0, in_coord_y = '0, in_coord_z = '0;
  logic signed [31:0] in_sample_a = '0, in_sample_b = '0, in_sample_c = '0;
  logic signed [31:0] in_sample_d = '0;
  logic out_valid;
  logic [1:0] out_status;
  logic signed [31:0] out_average_a, out_average_b, out_average_c, out_average_d;
  logic [63:0] out_total_weight;
  int error_count, pending_count;

  localparam int HOT_POINTS = 8;

  logic loaded [GRID_POINTS];
  logic [15:0] hot_x [HOT_POINTS], hot_y [HOT_POINTS], hot_z [HOT_POINTS];
  int burst_left;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  inverse_distance_scatter_accumulate_unit i_dut (.*);

  idsa_checker i_chk (.*);

  initial begin
    #400ms;
    $display("tb_top: done, errors");
    $finish;
  end

  // one transfer; the random gap between bursts falls before it
  task automatic send_item(logic [1:0] act, logic [11:0] idx, logic [15:0] x,
                           logic [15:0] y, logic [15:0] z, logic [31:0] a,
                           logic [31:0] b, logic [31:0] c, logic [31:0] d);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    start <= 1'b1;
    in_action <= act;
    in_grid_index <= idx;
    in_coord_x <= x;
    in_coord_y <= y;
    in_coord_z <= z;
    in_sample_a <= a;
    in_sample_b <= b;
    in_sample_c <= c;
    in_sample_d <= d;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (act == ACT_LOAD) loaded[idx] = 1'b1;
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      3: return $urandom_range(0, 131071) - 65536;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] near(logic [15:0] c);
    case ($urandom_range(0, 3))
      0: return c;
      1: return 16'(c + $urandom_range(0, 3) - 1);
      2: return 16'($urandom);
      default: return c ^ (16'd1 << $urandom_range(0, 15));
    endcase
  endfunction

  initial begin
    logic [1:0] act;
    logic [11:0] idx;
    int h;
    burst_left = 0;
    for (int i = 0; i < GRID_POINTS; i++) loaded[i] = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, zero distance, zero weight, unknown action
    send_item(ACT_LOAD, 12'd0, 16'h0, 16'h0, 16'h0, 0, 0, 0, 0);
    send_item(ACT_READ, 12'd0, 0, 0, 0, 0, 0, 0, 0);
    send_item(ACT_ACC, 12'd0, 16'h0, 16'h0, 16'h0, 1, 2, 3, 4);
    send_item(ACT_ACC, 12'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0001_0000);
    send_item(ACT_ACC, 12'd0, 16'h0001, 16'h0, 16'h0,
              32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_0000);
    send_item(ACT_READ, 12'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0);
    send_item(ACT_LOAD, 12'hFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0);
    for (int i = 0; i < 6; i++)
      send_item(ACT_ACC, 12'hFFF, 16'hFFFF, 16'hFFFF, 16'hFFFE,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(ACT_READ, 12'hFFF, 0, 0, 0, 0, 0, 0, 0);
    send_item(ACT_UNKNOWN, 12'hFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              '1, '1, '1, '1);
    send_item(ACT_LOAD, 12'hFFF, 16'h1234, 16'h8000, 16'h00FF, 0, 0, 0, 0);
    send_item(ACT_READ, 12'hFFF, 0, 0, 0, 0, 0, 0, 0);
    send_item(ACT_ACC, 12'hFFF, 16'h1234, 16'h8000, 16'h00FF, 5, 6, 7, 8);
    send_item(ACT_ACC, 12'hFFF, 16'h1334, 16'h7F00, 16'h01FF,
              32'hFFFE_8000, 32'h0003_0000, 32'h1, 32'hFFFF_FFFF);
    send_item(ACT_READ, 12'hFFF, 0, 0, 0, 0, 0, 0, 0);

    // random: a few hot points get most traffic so sums build up
    for (int j = 0; j < HOT_POINTS; j++) begin
      hot_x[j] = 16'($urandom);
      hot_y[j] = 16'($urandom);
      hot_z[j] = 16'($urandom);
    end
    for (int n = 0; n < 1400; n++) begin
      h = $urandom_range(0, HOT_POINTS - 1);
      idx = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'(h * 512 + 7);
      case ($urandom_range(0, 19))
        0, 1: act = ACT_LOAD;
        2: act = ACT_UNKNOWN;
        3, 4, 5, 6: act = ACT_READ;
        default: act = ACT_ACC;
      endcase
      if (act != ACT_LOAD && act != ACT_UNKNOWN && !loaded[idx]) act = ACT_LOAD;
      if (act == ACT_LOAD && idx == 12'(h * 512 + 7)) begin
        hot_x[h] = 16'($urandom);
        hot_y[h] = 16'($urandom);
        hot_z[h] = 16'($urandom);
        send_item(act, idx, hot_x[h], hot_y[h], hot_z[h],
                  $urandom, $urandom, $urandom, $urandom);
      end else if (act == ACT_ACC && idx == 12'(h * 512 + 7)) begin
        send_item(act, idx, near(hot_x[h]), near(hot_y[h]), near(hot_z[h]),
                  rand_sample(), rand_sample(), rand_sample(), rand_sample());
      end else begin
        send_item(act, idx, 16'($urandom), 16'($urandom), 16'($urandom),
                  rand_sample(), rand_sample(), rand_sample(), rand_sample());
      end
    end
    start <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule

/* filelist.f */
hw/rtl/idsa_pkg.sv
hw/rtl/idsa_ram.sv
hw/rtl/idsa_datapath.sv
hw/rtl/idsa_ctrl.sv
hw/rtl/inverse_distance_scatter_accumulate_unit.sv
test/idsa_checker.sv
test/tb_top.sv
